/* rtl/psic_pkg.sv */
// Shared types and constants for the pen stroke intent classifier.
`timescale 1ns / 1ps

package psic_pkg;

    localparam int COORD_BITS = 20;
    localparam int SLOP_W     = 16;
    localparam int SQ_W       = 2 * SLOP_W;
    localparam int CMP_W      = (COORD_BITS > SLOP_W) ? COORD_BITS : SLOP_W;

    localparam int S_USER_W = 4;
    localparam int S_DATA_W = ((4 + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_USER_W = 2;
    localparam int M_DATA_W = ((2 * COORD_BITS + 5 + 7) / 8) * 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [SLOP_W-1:0] SLOP_RESET = SLOP_W'(128);

    typedef enum logic [1:0] {
        ACT_PRESS  = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_RESET  = 2'd3
    } action_t;

    localparam logic [1:0] RK_MOVE = 2'd1;

    typedef enum logic [1:0] {
        CLS_TIP    = 2'd0,
        CLS_ERASER = 2'd1,
        CLS_BARREL = 2'd2
    } cls_t;

    typedef enum logic [1:0] {
        IK_BEGIN = 2'd0,
        IK_MOVE  = 2'd1,
        IK_END   = 2'd2,
        IK_MENU  = 2'd3
    } intent_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] report_kind;
        logic       pointer_is_eraser;
        logic       side_button;
        logic       in_contact;
        logic       eraser_supported;
        coord_t     pos_x;
        coord_t     pos_y;
    } item_t;

    typedef struct packed {
        intent_t    intent_kind;
        coord_t     out_x;
        coord_t     out_y;
        logic       erase_flag;
        logic       final_of_run;
        logic       stroke_active;
        cls_t       input_class;
        logic       now_erasing;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

/* rtl/psic_slop.sv */
// Slop threshold register and squared distance test against the stroke origin.
`timescale 1ns / 1ps

module psic_slop
    import psic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SLOP_W-1:0] cfg_data,
    input  coord_t            pos_x,
    input  coord_t            pos_y,
    input  coord_t            origin_x,
    input  coord_t            origin_y,
    output logic              beyond
);

    logic [SLOP_W-1:0]     slop_reg;
    logic [SQ_W-1:0]       slop_sq_reg;
    logic [COORD_BITS:0]   diff_x;
    logic [COORD_BITS:0]   diff_y;
    logic [COORD_BITS:0]   neg_x;
    logic [COORD_BITS:0]   neg_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [SLOP_W-1:0]     dx16;
    logic [SLOP_W-1:0]     dy16;
    logic [SQ_W-1:0]       sq_x;
    logic [SQ_W-1:0]       sq_y;
    logic [SQ_W:0]         sq_sum;
    logic                  axis_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slop_reg    <= SLOP_RESET;
            slop_sq_reg <= SQ_W'(SLOP_RESET) * SQ_W'(SLOP_RESET);
        end else if (cfg_valid) begin
            slop_reg    <= cfg_data;
            slop_sq_reg <= SQ_W'(cfg_data) * SQ_W'(cfg_data);
        end
    end

    assign diff_x = {pos_x[COORD_BITS-1], pos_x} - {origin_x[COORD_BITS-1], origin_x};
    assign diff_y = {pos_y[COORD_BITS-1], pos_y} - {origin_y[COORD_BITS-1], origin_y};
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign mag_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    assign mag_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

    assign axis_out = (CMP_W'(mag_x) > CMP_W'(slop_reg)) || (CMP_W'(mag_y) > CMP_W'(slop_reg));

    assign dx16   = SLOP_W'(mag_x);
    assign dy16   = SLOP_W'(mag_y);
    assign sq_x   = SQ_W'(dx16) * SQ_W'(dx16);
    assign sq_y   = SQ_W'(dy16) * SQ_W'(dy16);
    assign sq_sum = (SQ_W + 1)'(sq_x) + (SQ_W + 1)'(sq_y);

    assign beyond = axis_out || (sq_sum > (SQ_W + 1)'(slop_sq_reg));

endmodule

/* rtl/psic_core.sv */
// Input register, stroke state and intent decode for one report per cycle while the result queue has room.
`timescale 1ns / 1ps

module psic_core
    import psic_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    input  logic   room,
    input  logic   beyond,
    output coord_t cur_x,
    output coord_t cur_y,
    output coord_t org_x,
    output coord_t org_y,
    output logic   fire,
    output push_t  push
);

    logic   in_valid_reg;
    item_t  item_reg;

    logic   active_reg, active_next;
    cls_t   cls_reg, cls_next;
    logic   ea_reg, ea_next;
    logic   resolved_reg, resolved_next;
    coord_t origin_x_reg, origin_x_next;
    coord_t origin_y_reg, origin_y_next;
    coord_t recent_x_reg, recent_x_next;
    coord_t recent_y_reg, recent_y_next;

    logic [1:0] n;
    intent_t    k0, k1;
    coord_t     x0, y0, x1, y1;
    logic       e0;
    logic       erasing;
    cls_t       press_cls;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;
    assign cur_x    = item_reg.pos_x;
    assign cur_y    = item_reg.pos_y;
    assign org_x    = origin_x_reg;
    assign org_y    = origin_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign press_cls = item_reg.pointer_is_eraser ? CLS_ERASER :
                       (item_reg.side_button ? CLS_BARREL : CLS_TIP);

    always_comb begin
        active_next   = active_reg;
        cls_next      = cls_reg;
        ea_next       = ea_reg;
        resolved_next = resolved_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        recent_x_next = recent_x_reg;
        recent_y_next = recent_y_reg;
        n  = 2'd0;
        k0 = IK_BEGIN;
        k1 = IK_MOVE;
        x0 = item_reg.pos_x;
        y0 = item_reg.pos_y;
        x1 = item_reg.pos_x;
        y1 = item_reg.pos_y;
        e0 = 1'b0;
        unique case (item_reg.action)
            ACT_PRESS: begin
                active_next   = 1'b1;
                cls_next      = press_cls;
                origin_x_next = item_reg.pos_x;
                origin_y_next = item_reg.pos_y;
                recent_x_next = item_reg.pos_x;
                recent_y_next = item_reg.pos_y;
                ea_next       = item_reg.eraser_supported;
                resolved_next = 1'b0;
                if (press_cls == CLS_TIP) begin
                    n = 2'd1;
                end else if (press_cls == CLS_ERASER && item_reg.eraser_supported) begin
                    n  = 2'd1;
                    e0 = 1'b1;
                end
            end
            ACT_REPORT: begin
                if (active_reg && !item_reg.in_contact) begin
                    active_next   = 1'b0;
                    resolved_next = 1'b0;
                    k0 = IK_END;
                    if (cls_reg == CLS_TIP) begin
                        n = 2'd1;
                    end else if (cls_reg == CLS_BARREL) begin
                        if (!resolved_reg) begin
                            n  = 2'd1;
                            k0 = IK_MENU;
                            x0 = origin_x_reg;
                            y0 = origin_y_reg;
                        end else if (ea_reg) begin
                            n  = 2'd1;
                            e0 = 1'b1;
                        end
                    end else if (cls_reg == CLS_ERASER && ea_reg) begin
                        n  = 2'd1;
                        e0 = 1'b1;
                    end
                end else if (active_reg && item_reg.report_kind == RK_MOVE) begin
                    recent_x_next = item_reg.pos_x;
                    recent_y_next = item_reg.pos_y;
                    k0 = IK_MOVE;
                    if (cls_reg == CLS_TIP) begin
                        n = 2'd1;
                    end else if (cls_reg == CLS_ERASER) begin
                        if (ea_reg) begin
                            n  = 2'd1;
                            e0 = 1'b1;
                        end
                    end else if (cls_reg == CLS_BARREL) begin
                        if (!resolved_reg) begin
                            if (beyond) begin
                                resolved_next = 1'b1;
                                if (ea_reg) begin
                                    n  = 2'd2;
                                    k0 = IK_BEGIN;
                                    x0 = origin_x_reg;
                                    y0 = origin_y_reg;
                                    e0 = 1'b1;
                                end
                            end
                        end else if (ea_reg) begin
                            n  = 2'd1;
                            e0 = 1'b1;
                        end
                    end
                end
            end
            ACT_CANCEL: begin
                if (active_reg) begin
                    active_next   = 1'b0;
                    resolved_next = 1'b0;
                    k0 = IK_END;
                    x0 = recent_x_reg;
                    y0 = recent_y_reg;
                    if (cls_reg == CLS_TIP) begin
                        n = 2'd1;
                    end else if (cls_reg == CLS_ERASER && ea_reg) begin
                        n  = 2'd1;
                        e0 = 1'b1;
                    end else if (cls_reg == CLS_BARREL && resolved_reg && ea_reg) begin
                        n  = 2'd1;
                        e0 = 1'b1;
                    end
                end
            end
            ACT_RESET: begin
                active_next   = 1'b0;
                resolved_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cls_next == CLS_ERASER) begin
            erasing = ea_next;
        end else if (cls_next == CLS_BARREL) begin
            erasing = resolved_next && ea_next;
        end else begin
            erasing = 1'b0;
        end
    end

    always_comb begin
        push.cnt                    = n;
        push.res0.intent_kind       = k0;
        push.res0.out_x             = x0;
        push.res0.out_y             = y0;
        push.res0.erase_flag        = e0;
        push.res0.final_of_run      = (n != 2'd2);
        push.res0.stroke_active     = active_next;
        push.res0.input_class       = cls_next;
        push.res0.now_erasing       = erasing;
        push.res1.intent_kind       = k1;
        push.res1.out_x             = x1;
        push.res1.out_y             = y1;
        push.res1.erase_flag        = 1'b1;
        push.res1.final_of_run      = 1'b1;
        push.res1.stroke_active     = active_next;
        push.res1.input_class       = cls_next;
        push.res1.now_erasing       = erasing;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            cls_reg      <= CLS_TIP;
            ea_reg       <= 1'b0;
            resolved_reg <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            recent_x_reg <= '0;
            recent_y_reg <= '0;
        end else if (fire) begin
            active_reg   <= active_next;
            cls_reg      <= cls_next;
            ea_reg       <= ea_next;
            resolved_reg <= resolved_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            recent_x_reg <= recent_x_next;
            recent_y_reg <= recent_y_next;
        end
    end

`ifndef SYNTHESIS
    a_resolved_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> !resolved_reg)
        else $error("resolved set while no stroke is active");

    a_pair_only_on_crossing: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && push.cnt == 2'd2 |-> cls_reg == CLS_BARREL && !resolved_reg && active_reg)
        else $error("two intents outside a barrel slop crossing");

    a_fire_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> room && in_valid_reg)
        else $error("report decoded without queue room");
`endif

endmodule

/* rtl/psic_out_fifo.sv */
// Small result queue taking up to two beats per cycle and giving one while the reader is ready.
`timescale 1ns / 1ps

module psic_out_fifo
    import psic_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_en,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_AW-1:0]   wr_ptr_p1;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt  = push_en ? push.cnt : 2'd0;
    assign room      = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_AW'(1);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> room)
        else $error("push into a queue without room");
`endif

endmodule

/* rtl/pen_stroke_intent_classifier.sv */
// Top level: stylus reports in, stroke intents out.
// A report beat is held in the input register, decoded and written into the result queue, then sent on m_*.
// Throughput: one report per cycle while the result queue has room; a slop crossing pushes two intents into it.
// The four-entry result queue parts the two sides; decode waits while it has under two free.
// Reset (aresetn low, synchronous): idle stroke, tip class, zero positions, slop 128.
`timescale 1ns / 1ps

module pen_stroke_intent_classifier
    import psic_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // action[1:0], report_kind[3:2]
    input  logic [S_USER_W-1:0] s_tuser,
    // pointer_is_eraser, side_button, in_contact, eraser_supported, pos_x, pos_y, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // intent_kind[1:0]
    output logic [M_USER_W-1:0] m_tuser,
    // out_x, out_y, erase_flag, stroke_active, input_class[1:0], now_erasing, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SLOP_W-1:0]   cfg_data
);

    item_t   in_item;
    result_t out_item;
    push_t   push;
    logic    room;
    logic    fire;
    logic    beyond;
    coord_t  cur_x, cur_y, org_x, org_y;

    assign in_item.action            = action_t'(s_tuser[1:0]);
    assign in_item.report_kind       = s_tuser[3:2];
    assign in_item.pointer_is_eraser = s_tdata[0];
    assign in_item.side_button       = s_tdata[1];
    assign in_item.in_contact        = s_tdata[2];
    assign in_item.eraser_supported  = s_tdata[3];
    assign in_item.pos_x             = s_tdata[4 +: COORD_BITS];
    assign in_item.pos_y             = s_tdata[4 + COORD_BITS +: COORD_BITS];

    psic_slop u_slop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pos_x     (cur_x),
        .pos_y     (cur_y),
        .origin_x  (org_x),
        .origin_y  (org_y),
        .beyond    (beyond)
    );

    psic_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .room     (room),
        .beyond   (beyond),
        .cur_x    (cur_x),
        .cur_y    (cur_y),
        .org_x    (org_x),
        .org_y    (org_y),
        .fire     (fire),
        .push     (push)
    );

    psic_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (fire),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tuser = out_item.intent_kind;
    assign m_tlast = out_item.final_of_run;
    assign m_tdata = M_DATA_W'({out_item.now_erasing,
                                out_item.input_class,
                                out_item.stroke_active,
                                out_item.erase_flag,
                                out_item.out_y,
                                out_item.out_x});

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the pen stroke intent classifier with its own intent predictor.
`timescale 1ns / 1ps

module testbench;
    import psic_pkg::*;

    localparam logic [1:0] RK_PRESS   = 2'd0;
    localparam logic [1:0] RK_RELEASE = 2'd2;
    localparam logic [1:0] RK_SPARE   = 2'd3;
    localparam coord_t     C_MAX      = 2 ** (COORD_BITS - 1) - 1;
    localparam coord_t     C_MIN      = -(2 ** (COORD_BITS - 1));
    localparam int         ERASE_BIT  = 2 * COORD_BITS;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES = 300;
    localparam int         ITEMS_PER_PHASE = 125;

    class intent_scoreboard;
        logic [SLOP_W-1:0] slop;
        logic              active;
        cls_t              cls;
        logic              erase_ok;
        logic              resolved;
        coord_t            org_x;
        coord_t            org_y;
        coord_t            last_x;
        coord_t            last_y;
        result_t           batch[$];
        result_t           pending_intents[$];
        int                errors;

        function new();
            slop     = SLOP_RESET;
            active   = 1'b0;
            cls      = CLS_TIP;
            erase_ok = 1'b0;
            resolved = 1'b0;
            org_x    = '0;
            org_y    = '0;
            last_x   = '0;
            last_y   = '0;
            errors   = 0;
        endfunction

        function void set_slop(logic [SLOP_W-1:0] v);
            slop = v;
        endfunction

        function logic erasing();
            case (cls)
                CLS_ERASER: return erase_ok;
                CLS_BARREL: return resolved & erase_ok;
                default:    return 1'b0;
            endcase
        endfunction

        function bit outside_slop(coord_t x, coord_t y);
            longint dx;
            longint dy;
            longint s;
            dx = longint'(x) - longint'(org_x);
            dy = longint'(y) - longint'(org_y);
            s  = longint'(slop);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx > s || dy > s) return 1'b1;
            return (dx * dx + dy * dy) > (s * s);
        endfunction

        function void emit(intent_t k, coord_t x, coord_t y, logic er);
            result_t r;
            r = '0;
            r.intent_kind = k;
            r.out_x       = x;
            r.out_y       = y;
            r.erase_flag  = er;
            batch.push_back(r);
        endfunction

        function void note_report(item_t it);
            cls_t was_cls;
            logic was_resolved;
            batch.delete();
            case (it.action)
                ACT_PRESS: begin
                    active   = 1'b1;
                    cls      = it.pointer_is_eraser ? CLS_ERASER :
                               (it.side_button ? CLS_BARREL : CLS_TIP);
                    org_x    = it.pos_x;
                    org_y    = it.pos_y;
                    last_x   = it.pos_x;
                    last_y   = it.pos_y;
                    erase_ok = it.eraser_supported;
                    resolved = 1'b0;
                    if (cls == CLS_TIP) emit(IK_BEGIN, it.pos_x, it.pos_y, 1'b0);
                    else if (cls == CLS_ERASER && erase_ok)
                        emit(IK_BEGIN, it.pos_x, it.pos_y, 1'b1);
                end
                ACT_REPORT: begin
                    if (active && !it.in_contact) begin
                        active = 1'b0;
                        if (cls == CLS_TIP) begin
                            emit(IK_END, it.pos_x, it.pos_y, 1'b0);
                        end else if (cls == CLS_BARREL) begin
                            if (!resolved) emit(IK_MENU, org_x, org_y, 1'b0);
                            else if (erase_ok) emit(IK_END, it.pos_x, it.pos_y, 1'b1);
                        end else if (cls == CLS_ERASER && erase_ok) begin
                            emit(IK_END, it.pos_x, it.pos_y, 1'b1);
                        end
                        resolved = 1'b0;
                    end else if (active && it.report_kind == RK_MOVE) begin
                        last_x = it.pos_x;
                        last_y = it.pos_y;
                        if (cls == CLS_TIP) begin
                            emit(IK_MOVE, it.pos_x, it.pos_y, 1'b0);
                        end else if (cls == CLS_ERASER) begin
                            if (erase_ok) emit(IK_MOVE, it.pos_x, it.pos_y, 1'b1);
                        end else if (cls == CLS_BARREL) begin
                            if (!resolved) begin
                                if (outside_slop(it.pos_x, it.pos_y)) begin
                                    resolved = 1'b1;
                                    if (erase_ok) begin
                                        emit(IK_BEGIN, org_x, org_y, 1'b1);
                                        emit(IK_MOVE, it.pos_x, it.pos_y, 1'b1);
                                    end
                                end
                            end else if (erase_ok) begin
                                emit(IK_MOVE, it.pos_x, it.pos_y, 1'b1);
                            end
                        end
                    end
                end
                ACT_CANCEL: begin
                    if (active) begin
                        was_cls      = cls;
                        was_resolved = resolved;
                        active       = 1'b0;
                        resolved     = 1'b0;
                        if (was_cls == CLS_TIP)
                            emit(IK_END, last_x, last_y, 1'b0);
                        else if (was_cls == CLS_ERASER && erase_ok)
                            emit(IK_END, last_x, last_y, 1'b1);
                        else if (was_cls == CLS_BARREL && was_resolved && erase_ok)
                            emit(IK_END, last_x, last_y, 1'b1);
                    end
                end
                default: begin
                    active   = 1'b0;
                    resolved = 1'b0;
                end
            endcase
            foreach (batch[i]) begin
                batch[i].final_of_run  = (i == batch.size() - 1);
                batch[i].stroke_active = active;
                batch[i].input_class   = cls;
                batch[i].now_erasing   = erasing();
                pending_intents.push_back(batch[i]);
            end
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_intent(logic [M_USER_W-1:0] user, logic [M_DATA_W-1:0] data,
                                   logic last);
            result_t want;
            if (pending_intents.size() == 0) begin
                $error("intent beat with none expected: kind %0d", user);
                errors++;
                return;
            end
            want = pending_intents.pop_front();
            check_field("intent_kind", want.intent_kind, user);
            check_field("out_x", want.out_x, coord_t'(data[COORD_BITS-1:0]));
            check_field("out_y", want.out_y, coord_t'(data[2*COORD_BITS-1:COORD_BITS]));
            check_field("erase_flag", want.erase_flag, data[ERASE_BIT]);
            check_field("final_of_run", want.final_of_run, last);
            check_field("stroke_active", want.stroke_active, data[ERASE_BIT+1]);
            check_field("input_class", want.input_class, data[ERASE_BIT+3:ERASE_BIT+2]);
            check_field("now_erasing", want.now_erasing, data[ERASE_BIT+4]);
        endfunction

        function int pending();
            return pending_intents.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_USER_W-1:0] s_tuser;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_USER_W-1:0] m_tuser;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SLOP_W-1:0]   cfg_data;

    intent_scoreboard sb = new();
    bit               burst;
    bit               hold_request;
    int               stroke_items;
    int               cycles;

    pen_stroke_intent_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [1:0] rand_kind();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic item_t mk(action_t a, logic [1:0] rk, logic er, logic side,
                                 logic touch, logic sup, coord_t x, coord_t y);
        item_t it;
        it.action            = a;
        it.report_kind       = rk;
        it.pointer_is_eraser = er;
        it.side_button       = side;
        it.in_contact        = touch;
        it.eraser_supported  = sup;
        it.pos_x             = x;
        it.pos_y             = y;
        return it;
    endfunction

    function automatic coord_t near(coord_t o);
        longint span;
        span = longint'(sb.slop) * 3 / 2 + 8;
        if ($urandom_range(0, 15) == 0) return coord_t'($urandom);
        return coord_t'(longint'(o) + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {it.report_kind, it.action};
        s_tdata  <= S_DATA_W'({it.pos_y, it.pos_x, it.eraser_supported, it.in_contact,
                               it.side_button, it.pointer_is_eraser});
        do @(posedge aclk); while (!s_tready);
        sb.note_report(it);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slop(input logic [SLOP_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_slop(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 16, 16));
        send_item(mk(ACT_CANCEL, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 0, 0));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b0, 1'b1, 1'b1, C_MAX, C_MIN));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b1, C_MIN, C_MAX));
        send_item(mk(ACT_REPORT, RK_PRESS, 1'b0, 1'b0, 1'b1, 1'b0, 5, 5));
        send_item(mk(ACT_REPORT, RK_RELEASE, 1'b0, 1'b0, 1'b1, 1'b0, 6, 6));
        send_item(mk(ACT_REPORT, RK_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 7, 7));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b0, 1'b0, 1'b0, -3, 9));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b1, 1'b1, 1'b1, 1'b1, 0, 0));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b1, 1'b0, 1'b1, 1'b0, -40, 40));
        send_item(mk(ACT_CANCEL, RK_MOVE, 1'b1, 1'b0, 1'b1, 1'b0, 1000, 1000));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b1, 1'b0, 1'b1, 1'b0, 50, 50));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b1, 1'b0, 1'b1, 1'b0, 60, 60));
        send_item(mk(ACT_REPORT, RK_RELEASE, 1'b1, 1'b0, 1'b0, 1'b0, 70, 70));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b1, 1'b1, 1'b1, 100, 100));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b1, 228, 100));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b1, 190, 191));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b1, 191, 191));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b1, 300, 250));
        send_item(mk(ACT_REPORT, RK_PRESS, 1'b0, 1'b1, 1'b0, 1'b1, 310, 260));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b1, 1'b1, 1'b1, -500, 20));
        send_item(mk(ACT_REPORT, RK_RELEASE, 1'b0, 1'b1, 1'b0, 1'b1, -490, 25));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b1, 1'b1, 1'b0, 0, 0));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b0, 20000, 0));
        send_item(mk(ACT_CANCEL, RK_MOVE, 1'b0, 1'b1, 1'b1, 1'b0, 0, 0));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b1, 1'b1, 1'b1, 8, 8));
        send_item(mk(ACT_CANCEL, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 0, 0));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b0, 1'b0, 1'b1, 1'b0, 1, 2));
        send_item(mk(ACT_PRESS, RK_PRESS, 1'b1, 1'b0, 1'b1, 1'b1, 3, 4));
        send_item(mk(ACT_RESET, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 0, 0));
        send_item(mk(ACT_REPORT, RK_MOVE, 1'b0, 1'b0, 1'b1, 1'b0, 9, 9));
    endtask

    task automatic play_stroke();
        coord_t ox;
        coord_t oy;
        int     moves;
        int     r;
        item_t  it;
        if ($urandom_range(0, 11) == 0) burst = !burst;
        if ($urandom_range(0, 9) == 0) begin
            ox = coord_t'($urandom);
            oy = coord_t'($urandom);
        end else begin
            ox = coord_t'($urandom_range(0, 8192) - 4096);
            oy = coord_t'($urandom_range(0, 8192) - 4096);
        end
        send_item(mk(ACT_PRESS, rand_kind(), $urandom_range(0, 3) == 0,
                     rand_bit(), rand_bit(), $urandom_range(0, 3) != 0,
                     ox, oy));
        stroke_items++;
        moves = $urandom_range(0, 8);
        repeat (moves) begin
            if ($urandom_range(0, 7) == 0) begin
                it = mk(action_t'(rand_kind()), rand_kind(),
                        rand_bit(), rand_bit(), rand_bit(),
                        rand_bit(), coord_t'($urandom), coord_t'($urandom));
                send_item(it);
            end else begin
                send_item(mk(ACT_REPORT, RK_MOVE, rand_bit(), rand_bit(),
                             1'b1, rand_bit(), near(ox), near(oy)));
                stroke_items++;
            end
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            send_item(mk(ACT_REPORT, rand_kind(), rand_bit(),
                         rand_bit(), 1'b0, rand_bit(),
                         near(ox), near(oy)));
            stroke_items++;
        end else if (r < 17) begin
            send_item(mk(ACT_CANCEL, rand_kind(), rand_bit(),
                         rand_bit(), rand_bit(), rand_bit(),
                         coord_t'($urandom), coord_t'($urandom)));
            stroke_items++;
        end else if (r < 19) begin
            send_item(mk(ACT_RESET, rand_kind(), rand_bit(),
                         rand_bit(), rand_bit(), rand_bit(),
                         coord_t'($urandom), coord_t'($urandom)));
            stroke_items++;
        end
    endtask

    task automatic random_part(input int count);
        int goal;
        goal = stroke_items + count;
        while (stroke_items < goal) play_stroke();
    endtask

    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_intent(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [SLOP_W-1:0] slop_plan[5];
        burst        = 1'b0;
        hold_request = 1'b0;
        stroke_items = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = '0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        slop_plan    = '{16'd0, 16'hFFFF, SLOP_W'($urandom_range(2, 2000)), 16'd1, SLOP_RESET};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        random_part(ITEMS_PER_PHASE);
        foreach (slop_plan[i]) begin
            settle();
            write_slop(slop_plan[i]);
            if (i == 0) begin
                hold_request = 1'b1;
                burst        = 1'b1;
            end
            random_part(ITEMS_PER_PHASE);
        end
        settle();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
